// ===== rtl/core/ipv4sm_pkg.sv =====
package ipv4sm_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOID    = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] address;
    logic [31:0] mask;
    logic [6:0]  entry_id;
  } ipv4sm_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  found_id;
    logic [31:0] found_address;
    logic [31:0] found_mask;
    logic [6:0]  entry_count;
  } ipv4sm_out_t;

  // One stored record
  typedef struct packed {
    logic [6:0]  id;
    logic [31:0] addr;
    logic [31:0] mask;
  } ipv4sm_rec_t;

  // Search wave that travels down the chain, one cell per cycle
  typedef struct packed {
    logic        act;
    logic        found;
    ipv4sm_rec_t rec;
  } ipv4sm_wave_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] addr;
    logic [6:0]  want;
    logic        ins_we;
    ipv4sm_rec_t ins_rec;
    logic        apply;
  } ipv4sm_bcast_t;

endpackage

// ===== rtl/core/ipv4_subnet_match_table.sv =====
// Channel | Direction | Handshake             | Beat
// in      | input     | in_valid_i/in_stall_o  | ipv4sm_in_t (command, address, mask, entry_id)
// out     | output    | out_valid_o/out_stall_i| ipv4sm_out_t (status, ids, address, mask, count)
//
// Insert and the unused command are answered from the idle state without a search.
// Lookup and delete launch the search wave from a register, let it cross the cell
// chain one cell per cycle, catch it in the controller's result register in the scan
// state, then commit and present the result beat once the output slot is free.
// Reset clears the entry count and the handshake state; records stay undefined until
// written.
// A result beat held by out_stall_i stalls the input side until it is taken.
module ipv4_subnet_match_table
  import ipv4sm_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ipv4sm_in_t  in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ipv4sm_out_t out_data_o
);

  localparam int unsigned CW = $clog2(ENTRIES + 1);

  ipv4sm_bcast_t bc;
  logic [CW-1:0] count;
  // wave_c[i] enters cell i; wave_c[ENTRIES] returns to the controller
  ipv4sm_wave_t  wave_c [ENTRIES+1];
  // rec_c[i] is cell i's record; the slot past the end feeds the last cell on a shift
  ipv4sm_rec_t   rec_c  [ENTRIES+1];

  assign rec_c[ENTRIES] = '0;

  ipv4sm_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .bc_o        (bc),
    .count_o     (count),
    .wave_o      (wave_c[0]),
    .wave_i      (wave_c[ENTRIES])
  );

  // One cell per record, storage order runs from cell 0 upward
  for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
    ipv4sm_cell #(
      .ENTRIES (ENTRIES),
      .IDX     (gi)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .bc_i       (bc),
      .count_i    (count),
      .wave_i     (wave_c[gi]),
      .wave_o     (wave_c[gi+1]),
      .next_rec_i (rec_c[gi+1]),
      .rec_o      (rec_c[gi])
    );
  end

endmodule

// ===== rtl/core/ipv4sm_cell.sv =====
module ipv4sm_cell
  import ipv4sm_pkg::*;
#(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned IDX     = 0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ipv4sm_bcast_t                      bc_i,
  input  logic [$clog2(ENTRIES+1)-1:0]       count_i,
  input  ipv4sm_wave_t                       wave_i,
  output ipv4sm_wave_t                       wave_o,
  input  ipv4sm_rec_t                        next_rec_i,
  output ipv4sm_rec_t                        rec_o
);

  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  ipv4sm_rec_t  rec_q, rec_d;
  ipv4sm_wave_t wave_q, wave_d;
  logic         shift_q, shift_d;
  logic         valid, is_lkp, is_del, hit;

  always_comb begin
    valid  = count_i > MyIdx;
    is_lkp = bc_i.cmd == CMD_LOOKUP;
    is_del = bc_i.cmd == CMD_DELETE;
    hit    = valid && (is_lkp ? (((bc_i.addr ^ rec_q.addr) & rec_q.mask) == 32'd0)
                              : (is_del && (rec_q.id == bc_i.want)));

    // take the wave over if nobody upstream matched
    wave_d = wave_i;
    if (wave_i.act && !wave_i.found && hit) begin
      wave_d.found = 1'b1;
      wave_d.rec   = rec_q;
    end

    // mark cells at or past the deleted record
    shift_d = shift_q;
    if (wave_i.act) begin
      shift_d = is_del && (wave_i.found || hit);
    end else if (bc_i.apply) begin
      shift_d = 1'b0;
    end

    rec_d = rec_q;
    if (bc_i.ins_we && (count_i == MyIdx)) begin
      rec_d = bc_i.ins_rec;
    end else if (bc_i.apply && shift_q) begin
      rec_d = next_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q  <= '0;
      shift_q <= 1'b0;
    end else begin
      wave_q  <= wave_d;
      shift_q <= shift_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign wave_o = wave_q;
  assign rec_o  = rec_q;

endmodule

// ===== rtl/core/ipv4sm_ctrl.sv =====
module ipv4sm_ctrl
  import ipv4sm_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  ipv4sm_in_t                         in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output ipv4sm_out_t                        out_data_o,
  output ipv4sm_bcast_t                      bc_o,
  output logic [$clog2(ENTRIES+1)-1:0]       count_o,
  output ipv4sm_wave_t                       wave_o,
  input  ipv4sm_wave_t                       wave_i
);

  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] Full = CW'(ENTRIES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          start_q, start_d;
  logic [1:0]    cmd_q, cmd_d;
  logic [31:0]   addr_q, addr_d;
  logic [6:0]    want_q, want_d;
  ipv4sm_wave_t  res_q, res_d;
  logic          out_valid_q, out_valid_d;
  ipv4sm_out_t   out_q, out_d;

  logic          slot_free, in_fire, ins_we, apply;
  logic [CW-1:0] count_inc, count_dec;
  logic [CW+6:0] ext_inc, ext_dec, ext_cnt;

  always_comb begin
    slot_free  = !out_valid_q || !out_stall_i;
    in_stall_o = (state_q != S_IDLE) || !slot_free;
    in_fire    = in_valid_i && !in_stall_o;
    count_inc  = count_q + 1'b1;
    count_dec  = count_q - 1'b1;
    ext_inc    = {7'd0, count_inc};
    ext_dec    = {7'd0, count_dec};
    ext_cnt    = {7'd0, count_q};

    state_d     = state_q;
    count_d     = count_q;
    start_d     = 1'b0;
    cmd_d       = cmd_q;
    addr_d      = addr_q;
    want_d      = want_q;
    res_d       = res_q;
    out_d       = out_q;
    ins_we      = 1'b0;
    apply       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_d  = in_data_i.command;
          addr_d = in_data_i.address;
          want_d = in_data_i.entry_id;
          case (in_data_i.command) inside
            CMD_INSERT: begin
              out_valid_d = 1'b1;
              if (count_q == Full) begin
                out_d = '{status: ST_FULL, found_id: 7'd0, found_address: 32'd0,
                          found_mask: 32'd0, entry_count: ext_cnt[6:0]};
              end else begin
                ins_we  = 1'b1;
                count_d = count_inc;
                out_d   = '{status: ST_OK, found_id: ext_inc[6:0],
                            found_address: in_data_i.address,
                            found_mask: in_data_i.mask, entry_count: ext_inc[6:0]};
              end
            end
            CMD_DELETE, CMD_LOOKUP: begin
              start_d = 1'b1;
              state_d = S_SCAN;
            end
            default: begin
              out_valid_d = 1'b1;
              out_d = '{status: ST_OK, found_id: 7'd0, found_address: 32'd0,
                        found_mask: 32'd0, entry_count: ext_cnt[6:0]};
            end
          endcase
        end
      end
      S_SCAN: begin
        // hold until the wave leaves the last cell
        if (wave_i.act) begin
          res_d   = wave_i;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (res_q.found) begin
            if (cmd_q == CMD_DELETE) begin
              apply   = 1'b1;
              count_d = count_dec;
            end
            out_d = '{status: ST_OK, found_id: res_q.rec.id,
                      found_address: res_q.rec.addr, found_mask: res_q.rec.mask,
                      entry_count: (cmd_q == CMD_DELETE) ? ext_dec[6:0] : ext_cnt[6:0]};
          end else begin
            out_d = '{status: (cmd_q == CMD_DELETE) ? ST_NOID : ST_NOMATCH,
                      found_id: 7'd0, found_address: 32'd0, found_mask: 32'd0,
                      entry_count: ext_cnt[6:0]};
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    addr_q <= addr_d;
    want_q <= want_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  always_comb begin
    bc_o.cmd         = cmd_q;
    bc_o.addr        = addr_q;
    bc_o.want        = want_q;
    bc_o.ins_we      = ins_we;
    bc_o.ins_rec     = '{id: ext_inc[6:0], addr: in_data_i.address, mask: in_data_i.mask};
    bc_o.apply       = apply;
    wave_o           = '0;
    wave_o.act       = start_q;
  end

  assign count_o     = count_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_wave_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wave_i.act |-> state_q == S_SCAN)
    else $error("search wave returned outside of scan");

  a_start_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> state_q == S_SCAN)
    else $error("search wave launched outside of scan");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("entry count beyond table size");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_we |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not advance entry count");

endmodule
